>>> rtl/core/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// Types, constants and helpers shared by the lidar ray to point pipeline.
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int RANGE_W     = 16;
    localparam int ANG_W       = 16;
    localparam int HIDX_W      = 12;
    localparam int VIDX_W      = 8;
    localparam int COORD_W     = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int CORDIC_ITERS = 18;
    localparam int TURN_W       = 24;
    localparam int Z_W          = 26;
    localparam int XY_W         = 32;
    localparam int ROUND_W      = 20;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;
    localparam logic signed [ROUND_W-1:0] OUT_LIMIT = 20'sd65535;

    localparam logic signed [Z_W-1:0] ATAN_TURN [CORDIC_ITERS] = '{
        26'sd2097152, 26'sd1238021, 26'sd654136, 26'sd332050, 26'sd166669,
        26'sd83416,   26'sd41718,   26'sd20860,  26'sd10430,  26'sd5215,
        26'sd2608,    26'sd1304,    26'sd652,    26'sd326,    26'sd163,
        26'sd81,      26'sd41,      26'sd20
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YAW_START   = 3'd0,
        CFG_YAW_STEP    = 3'd1,
        CFG_PITCH_START = 3'd2,
        CFG_PITCH_STEP  = 3'd3,
        CFG_MAX_RANGE   = 3'd4,
        CFG_RANGE_FLOOR = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [ANG_W-1:0]   yaw_start;
        logic [ANG_W-1:0]   yaw_step;
        logic [ANG_W-1:0]   pitch_start;
        logic [ANG_W-1:0]   pitch_step;
        logic [RANGE_W-1:0] max_range;
        logic [RANGE_W-1:0] range_floor;
    } cfg_t;

    typedef struct packed {
        logic [RANGE_W-1:0]       range;
        logic signed [TURN_W-1:0] z_yaw;
        logic                     neg_yaw;
        logic signed [TURN_W-1:0] z_pitch;
        logic                     neg_pitch;
    } ang_item_t;

    typedef struct packed {
        logic [RANGE_W-1:0]     range;
        logic signed [XY_W-1:0] cos_y;
        logic signed [XY_W-1:0] sin_y;
        logic                   neg_y;
        logic signed [XY_W-1:0] cos_p;
        logic signed [XY_W-1:0] sin_p;
        logic                   neg_p;
    } cord_item_t;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [ROUND_W-1:0] v);
        logic signed [ROUND_W-1:0] c;
        begin
            c = v;
            if (v > OUT_LIMIT)
            begin
                c = OUT_LIMIT;
            end
            else if (v < -OUT_LIMIT)
            begin
                c = -OUT_LIMIT;
            end
            return c[COORD_W-1:0];
        end
    endfunction

endpackage

>>> rtl/core/lrc_if.sv
// ----------------------------------------------------------------------------
// lrc_if
// Stream interfaces for lidar rays in and Cartesian points out.
// ----------------------------------------------------------------------------
interface lrc_ray_if;
    logic                         valid;
    logic                         ready;
    logic [lrc_pkg::RANGE_W-1:0]  range_mm;
    logic                         no_hit;
    logic [lrc_pkg::HIDX_W-1:0]   horiz_index;
    logic [lrc_pkg::VIDX_W-1:0]   vert_index;

    modport source (output valid, range_mm, no_hit, horiz_index, vert_index, input ready);
    modport sink   (input valid, range_mm, no_hit, horiz_index, vert_index, output ready);
endinterface

interface lrc_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [lrc_pkg::COORD_W-1:0]  x_mm;
    logic signed [lrc_pkg::COORD_W-1:0]  y_mm;
    logic signed [lrc_pkg::COORD_W-1:0]  z_mm;

    modport source (output valid, x_mm, y_mm, z_mm, input ready);
    modport sink   (input valid, x_mm, y_mm, z_mm, output ready);
endinterface

>>> rtl/core/lrc_front.sv
// ----------------------------------------------------------------------------
// lrc_front
// Ray filter, yaw/pitch angle generation and quadrant fold (two stages).
// ----------------------------------------------------------------------------
module lrc_front #(
    parameter int MAX_HORIZ_RAYS = 4096,
    parameter int MAX_VERT_ROWS  = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  lrc_pkg::cfg_t       cfg,
    lrc_ray_if.sink             ray,
    output logic                out_valid,
    input  logic                out_ready,
    output lrc_pkg::ang_item_t  out_item
);

    logic                          en;
    logic                          keep;
    logic [27:0]                   yaw_prod;
    logic [23:0]                   pitch_prod;
    logic [lrc_pkg::ANG_W-1:0]     yaw_ang;
    logic [lrc_pkg::ANG_W-1:0]     pitch_ang;
    logic                          yaw_neg;
    logic                          pitch_neg;

    logic                          s1_valid_reg;
    logic [lrc_pkg::RANGE_W-1:0]   s1_range_reg;
    logic [lrc_pkg::ANG_W-1:0]     s1_yoff_reg;
    logic [lrc_pkg::ANG_W-1:0]     s1_poff_reg;
    logic                          s2_valid_reg;
    lrc_pkg::ang_item_t            s2_item_reg;

    assign en        = !s2_valid_reg || out_ready;
    assign ray.ready = en;

    always_comb
    begin
        keep = !ray.no_hit
            && (ray.range_mm < cfg.max_range)
            && (ray.range_mm >= cfg.range_floor)
            && (32'(ray.horiz_index) < 32'(MAX_HORIZ_RAYS))
            && (32'(ray.vert_index) < 32'(MAX_VERT_ROWS));
        yaw_prod   = 28'(ray.horiz_index) * 28'(cfg.yaw_step);
        pitch_prod = 24'(ray.vert_index) * 24'(cfg.pitch_step);
        yaw_ang    = cfg.yaw_start + s1_yoff_reg;
        pitch_ang  = cfg.pitch_start + s1_poff_reg;
        // second and third quadrant fold by a half turn
        yaw_neg    = yaw_ang[15] ^ yaw_ang[14];
        pitch_neg  = pitch_ang[15] ^ pitch_ang[14];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg <= ray.valid && keep;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_range_reg          <= ray.range_mm;
            s1_yoff_reg           <= yaw_prod[15:0];
            s1_poff_reg           <= pitch_prod[15:0];
            s2_item_reg.range     <= s1_range_reg;
            s2_item_reg.z_yaw     <= {yaw_ang[15] ^ yaw_neg, yaw_ang[14:0], 8'd0};
            s2_item_reg.neg_yaw   <= yaw_neg;
            s2_item_reg.z_pitch   <= {pitch_ang[15] ^ pitch_neg, pitch_ang[14:0], 8'd0};
            s2_item_reg.neg_pitch <= pitch_neg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

>>> rtl/core/lrc_cordic.sv
// ----------------------------------------------------------------------------
// lrc_cordic
// Two-lane rotation CORDIC, one iteration per stage (yaw lane 0, pitch lane 1).
// ----------------------------------------------------------------------------
module lrc_cordic (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lrc_pkg::ang_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output lrc_pkg::cord_item_t out_item
);

    localparam int N = lrc_pkg::CORDIC_ITERS;

    logic                              en;
    logic                              v_reg   [N];
    logic [lrc_pkg::RANGE_W-1:0]       rng_reg [N];
    logic                              neg_reg [N][2];
    logic signed [lrc_pkg::XY_W-1:0]   x_reg   [N][2];
    logic signed [lrc_pkg::XY_W-1:0]   y_reg   [N][2];
    logic signed [lrc_pkg::Z_W-1:0]    z_reg   [N][2];

    logic signed [lrc_pkg::XY_W-1:0]   x_src   [N][2];
    logic signed [lrc_pkg::XY_W-1:0]   y_src   [N][2];
    logic signed [lrc_pkg::Z_W-1:0]    z_src   [N][2];
    logic signed [lrc_pkg::XY_W-1:0]   x_next  [N][2];
    logic signed [lrc_pkg::XY_W-1:0]   y_next  [N][2];
    logic signed [lrc_pkg::Z_W-1:0]    z_next  [N][2];

    assign en       = !v_reg[N-1] || out_ready;
    assign in_ready = en;

    assign x_src[0][0] = lrc_pkg::CORDIC_GAIN;
    assign x_src[0][1] = lrc_pkg::CORDIC_GAIN;
    assign y_src[0][0] = '0;
    assign y_src[0][1] = '0;
    assign z_src[0][0] = lrc_pkg::Z_W'(in_item.z_yaw);
    assign z_src[0][1] = lrc_pkg::Z_W'(in_item.z_pitch);

    genvar k, l;
    generate
        for (k = 1; k < N; k++)
        begin : g_link
            for (l = 0; l < 2; l++)
            begin : g_lane
                assign x_src[k][l] = x_reg[k-1][l];
                assign y_src[k][l] = y_reg[k-1][l];
                assign z_src[k][l] = z_reg[k-1][l];
            end
        end

        for (k = 0; k < N; k++)
        begin : g_iter
            for (l = 0; l < 2; l++)
            begin : g_lane
                always_comb
                begin
                    if (!z_src[k][l][lrc_pkg::Z_W-1])
                    begin
                        x_next[k][l] = x_src[k][l] - (y_src[k][l] >>> k);
                        y_next[k][l] = y_src[k][l] + (x_src[k][l] >>> k);
                        z_next[k][l] = z_src[k][l] - lrc_pkg::ATAN_TURN[k];
                    end
                    else
                    begin
                        x_next[k][l] = x_src[k][l] + (y_src[k][l] >>> k);
                        y_next[k][l] = y_src[k][l] - (x_src[k][l] >>> k);
                        z_next[k][l] = z_src[k][l] + lrc_pkg::ATAN_TURN[k];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        x_reg[k][l] <= x_next[k][l];
                        y_reg[k][l] <= y_next[k][l];
                        z_reg[k][l] <= z_next[k][l];
                    end
                end
            end

            if (k == 0)
            begin : g_head
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        v_reg[k] <= 1'b0;
                    end
                    else if (en)
                    begin
                        v_reg[k] <= in_valid;
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rng_reg[k]    <= in_item.range;
                        neg_reg[k][0] <= in_item.neg_yaw;
                        neg_reg[k][1] <= in_item.neg_pitch;
                    end
                end
            end
            else
            begin : g_body
                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                    begin
                        v_reg[k] <= 1'b0;
                    end
                    else if (en)
                    begin
                        v_reg[k] <= v_reg[k-1];
                    end
                end

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        rng_reg[k]    <= rng_reg[k-1];
                        neg_reg[k][0] <= neg_reg[k-1][0];
                        neg_reg[k][1] <= neg_reg[k-1][1];
                    end
                end
            end
        end
    endgenerate

    assign out_valid      = v_reg[N-1];
    assign out_item.range = rng_reg[N-1];
    assign out_item.cos_y = x_reg[N-1][0];
    assign out_item.sin_y = y_reg[N-1][0];
    assign out_item.neg_y = neg_reg[N-1][0];
    assign out_item.cos_p = x_reg[N-1][1];
    assign out_item.sin_p = y_reg[N-1][1];
    assign out_item.neg_p = neg_reg[N-1][1];

endmodule

>>> rtl/core/lrc_back.sv
// ----------------------------------------------------------------------------
// lrc_back
// Sign fix, range scaling, rounding and saturation to the point output.
// ----------------------------------------------------------------------------
module lrc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  lrc_pkg::cord_item_t in_item,
    lrc_point_if.source         point
);

    localparam int RC_W   = 49;
    localparam int PROD_W = 64;

    logic                                en;
    logic                                b1_valid_reg;
    logic                                b2_valid_reg;
    logic                                b3_valid_reg;
    logic                                b4_valid_reg;

    logic [lrc_pkg::RANGE_W-1:0]         b1_range_reg;
    logic signed [lrc_pkg::XY_W-1:0]     b1_cy_reg;
    logic signed [lrc_pkg::XY_W-1:0]     b1_sy_reg;
    logic signed [lrc_pkg::XY_W-1:0]     b1_cp_reg;
    logic signed [lrc_pkg::XY_W-1:0]     b1_sp_reg;

    logic signed [lrc_pkg::XY_W-1:0]     b2_rc_reg;
    logic signed [lrc_pkg::ROUND_W-1:0]  b2_z_reg;
    logic signed [lrc_pkg::XY_W-1:0]     b2_cy_reg;
    logic signed [lrc_pkg::XY_W-1:0]     b2_sy_reg;

    logic signed [PROD_W-1:0]            b3_px_reg;
    logic signed [PROD_W-1:0]            b3_py_reg;
    logic signed [lrc_pkg::ROUND_W-1:0]  b3_z_reg;

    logic [lrc_pkg::COORD_W-1:0]         b4_x_reg;
    logic [lrc_pkg::COORD_W-1:0]         b4_y_reg;
    logic [lrc_pkg::COORD_W-1:0]         b4_z_reg;

    logic signed [RC_W-1:0]              r_s;
    logic signed [RC_W-1:0]              rc_sum;
    logic signed [RC_W-1:0]              rz_sum;
    logic signed [PROD_W-1:0]            x_sum;
    logic signed [PROD_W-1:0]            y_sum;

    assign en       = !b4_valid_reg || point.ready;
    assign in_ready = en;

    always_comb
    begin
        r_s    = $signed({{(RC_W-lrc_pkg::RANGE_W){1'b0}}, b1_range_reg});
        rc_sum = r_s * RC_W'(b1_cp_reg) + (RC_W'(1) <<< 15);
        rz_sum = r_s * RC_W'(b1_sp_reg) + (RC_W'(1) <<< 29);
        x_sum  = b3_px_reg + (PROD_W'(1) <<< 43);
        y_sum  = b3_py_reg + (PROD_W'(1) <<< 43);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
            b4_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b1_valid_reg <= in_valid;
            b2_valid_reg <= b1_valid_reg;
            b3_valid_reg <= b2_valid_reg;
            b4_valid_reg <= b3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b1_range_reg <= in_item.range;
            b1_cy_reg    <= in_item.neg_y ? -in_item.cos_y : in_item.cos_y;
            b1_sy_reg    <= in_item.neg_y ? -in_item.sin_y : in_item.sin_y;
            b1_cp_reg    <= in_item.neg_p ? -in_item.cos_p : in_item.cos_p;
            b1_sp_reg    <= in_item.neg_p ? -in_item.sin_p : in_item.sin_p;

            b2_rc_reg    <= lrc_pkg::XY_W'(rc_sum >>> 16);
            b2_z_reg     <= lrc_pkg::ROUND_W'(rz_sum >>> 30);
            b2_cy_reg    <= b1_cy_reg;
            b2_sy_reg    <= b1_sy_reg;

            b3_px_reg    <= PROD_W'(b2_rc_reg) * PROD_W'(b2_cy_reg);
            b3_py_reg    <= PROD_W'(b2_rc_reg) * PROD_W'(b2_sy_reg);
            b3_z_reg     <= b2_z_reg;

            b4_x_reg     <= lrc_pkg::sat_coord(lrc_pkg::ROUND_W'(x_sum >>> 44));
            b4_y_reg     <= lrc_pkg::sat_coord(lrc_pkg::ROUND_W'(y_sum >>> 44));
            b4_z_reg     <= lrc_pkg::sat_coord(b3_z_reg);
        end
    end

    assign point.valid = b4_valid_reg;
    assign point.x_mm  = b4_x_reg;
    assign point.y_mm  = b4_y_reg;
    assign point.z_mm  = b4_z_reg;

endmodule

>>> rtl/core/lidar_ray_to_cartesian_point_core.sv
// Pipeline: front end, then the 18-stage CORDIC that sets the depth, then back end.
// Throughput: one ray per cycle unless the point output applies back-pressure.
// Dropped rays leave a bubble and produce no point.
// Reset: asynchronous active-low; clears all valid bits and the registers
// to their defaults (max_range 65535, range floor 500, angles zero).
// ----------------------------------------------------------------------------
// lidar_ray_to_cartesian_point_core
// Converts lidar rays (range, indices) into filtered Cartesian points.
// ----------------------------------------------------------------------------
module lidar_ray_to_cartesian_point_core #(
    parameter int MAX_HORIZ_RAYS = 4096,
    parameter int MAX_VERT_ROWS  = 256
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [lrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lrc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    lrc_ray_if.sink                            ray,
    lrc_point_if.source                        point
);

    lrc_pkg::cfg_t       cfg_reg;
    logic                fr_valid;
    logic                fr_ready;
    lrc_pkg::ang_item_t  fr_item;
    logic                co_valid;
    logic                co_ready;
    lrc_pkg::cord_item_t co_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.yaw_start   <= '0;
            cfg_reg.yaw_step    <= '0;
            cfg_reg.pitch_start <= '0;
            cfg_reg.pitch_step  <= '0;
            cfg_reg.max_range   <= 16'd65535;
            cfg_reg.range_floor <= 16'd500;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                lrc_pkg::CFG_YAW_START:   cfg_reg.yaw_start   <= cfg_wdata;
                lrc_pkg::CFG_YAW_STEP:    cfg_reg.yaw_step    <= cfg_wdata;
                lrc_pkg::CFG_PITCH_START: cfg_reg.pitch_start <= cfg_wdata;
                lrc_pkg::CFG_PITCH_STEP:  cfg_reg.pitch_step  <= cfg_wdata;
                lrc_pkg::CFG_MAX_RANGE:   cfg_reg.max_range   <= cfg_wdata;
                lrc_pkg::CFG_RANGE_FLOOR: cfg_reg.range_floor <= cfg_wdata;
                default:                  cfg_reg             <= cfg_reg;
            endcase
        end
    end

    lrc_front #(
        .MAX_HORIZ_RAYS (MAX_HORIZ_RAYS),
        .MAX_VERT_ROWS  (MAX_VERT_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ray       (ray),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    lrc_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_item   (fr_item),
        .out_valid (co_valid),
        .out_ready (co_ready),
        .out_item  (co_item)
    );

    lrc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (co_valid),
        .in_ready (co_ready),
        .in_item  (co_item),
        .point    (point)
    );

`ifndef SYNTH
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !ray.ready |-> (point.valid && !point.ready))
        else $error("input stalled without output backpressure");

    a_coord_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid |-> (point.x_mm != 17'h10000) && (point.y_mm != 17'h10000)
                        && (point.z_mm != 17'h10000))
        else $error("coordinate outside saturation limits");

    a_empty_after_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !point.valid)
        else $error("point valid right after reset");
`endif

endmodule

>>> bench/lrc_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lrc_tb_pkg
// Bench-side fixed-point model of the ray to point conversion: register
// state, CORDIC sine/cosine and the rounding and saturation of each axis.
// ----------------------------------------------------------------------------
package lrc_tb_pkg;

    import lrc_pkg::*;

    typedef struct packed {
        logic [RANGE_W-1:0] range_mm;
        logic               no_hit;
        logic [HIDX_W-1:0]  horiz_index;
        logic [VIDX_W-1:0]  vert_index;
    } ray_t;

    typedef struct packed {
        logic [COORD_W-1:0] x_mm;
        logic [COORD_W-1:0] y_mm;
        logic [COORD_W-1:0] z_mm;
    } point_t;

    localparam longint ARCTAN_TURN [18] = '{
        2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20
    };

    // floor shift on 64-bit signed values
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic void trig_of_angle(input logic [15:0] ang,
                                          output longint c, output longint s);
        logic [23:0] a;
        logic [1:0]  q;
        bit          flip;
        longint      x, y, z, t;
        a = {ang, 8'h00};
        q = a[23:22];
        flip = (q == 2'd1 || q == 2'd2);
        if (flip)
        begin
            a = a - 24'h800000;
        end
        z = longint'($signed(a));
        x = 652032874;
        y = 0;
        for (int i = 0; i < 18; i++)
        begin
            if (z >= 0)
            begin
                t = x - floor_shift(y, i);
                y = y + floor_shift(x, i);
                z = z - ARCTAN_TURN[i];
            end
            else
            begin
                t = x + floor_shift(y, i);
                y = y - floor_shift(x, i);
                z = z + ARCTAN_TURN[i];
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic logic [COORD_W-1:0] clamp_axis(longint v);
        if (v > 65535)
        begin
            v = 65535;
        end
        if (v < -65535)
        begin
            v = -65535;
        end
        return v[COORD_W-1:0];
    endfunction

    // returns 1 and the point when the ray survives the range filter
    function automatic bit ray_to_point(input cfg_t cfg, input ray_t r,
                                        output point_t p);
        logic [15:0] yaw, pitch;
        longint      cy, sy, cp, sp, rc, rng;
        p = '0;
        if (r.no_hit || r.range_mm >= cfg.max_range || r.range_mm < cfg.range_floor)
        begin
            return 0;
        end
        yaw = cfg.yaw_start + 16'(r.horiz_index * cfg.yaw_step);
        pitch = cfg.pitch_start + 16'(r.vert_index * cfg.pitch_step);
        trig_of_angle(yaw, cy, sy);
        trig_of_angle(pitch, cp, sp);
        rng = longint'(r.range_mm);
        rc = floor_shift(rng * cp + (64'sd1 <<< 15), 16);
        p.x_mm = clamp_axis(floor_shift(rc * cy + (64'sd1 <<< 43), 44));
        p.y_mm = clamp_axis(floor_shift(rc * sy + (64'sd1 <<< 43), 44));
        p.z_mm = clamp_axis(floor_shift(rng * sp + (64'sd1 <<< 29), 30));
        return 1;
    endfunction

endpackage

>>> bench/lrc_tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives rays into the point converter with random gaps, back-pressure and
// several register settings; each point is checked against a bench model.
// ----------------------------------------------------------------------------
module testbench;

    import lrc_pkg::*;
    import lrc_tb_pkg::*;

    localparam int LATENCY   = 24;
    localparam int IDLE_MAX  = 20000;
    localparam int N_RANDOM  = 1450;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lrc_ray_if   ray ();
    lrc_point_if point ();

    lidar_ray_to_cartesian_point_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .ray       (ray.sink),
        .point     (point.source)
    );

    cfg_t   reg_shadow;
    point_t pending_points[$];
    int     fail_count;
    int     rays_sent;
    int     points_seen;
    int     idle_cycles;
    bit     hold_long;

    typedef struct {
        ray_t   r;
        bit     typed;
        bit     hit;
        point_t p;
    } row_t;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int d;
        d = $urandom_range(0, 99);
        if (d < 55)
        begin
            return 0;
        end
        if (d < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_YAW_START:   reg_shadow.yaw_start = val;
            CFG_YAW_STEP:    reg_shadow.yaw_step = val;
            CFG_PITCH_START: reg_shadow.pitch_start = val;
            CFG_PITCH_STEP:  reg_shadow.pitch_step = val;
            CFG_MAX_RANGE:   reg_shadow.max_range = val;
            default:         reg_shadow.range_floor = val;
        endcase
        @(posedge clk);
    endtask

    task automatic drain();
        ray.valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic send_ray(ray_t r, bit typed, bit hit, point_t p);
        point_t exp_p;
        bit     exp_hit;
        int     gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            ray.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ray.valid <= 1'b1;
        {ray.range_mm, ray.no_hit, ray.horiz_index, ray.vert_index} <= r;
        do
        begin
            @(posedge clk);
        end
        while (!ray.ready);
        exp_hit = ray_to_point(reg_shadow, r, exp_p);
        if (typed)
        begin
            exp_hit = hit;
            exp_p = p;
        end
        if (exp_hit)
        begin
            pending_points.push_back(exp_p);
        end
        rays_sent++;
    endtask

    function automatic ray_t rand_ray();
        ray_t r;
        r.range_mm = ($urandom_range(0, 3) == 0) ? 16'($urandom())
                                                 : 16'($urandom_range(0, 20000));
        r.no_hit = ($urandom_range(0, 9) == 0);
        r.horiz_index = 12'($urandom());
        r.vert_index = 8'($urandom());
        return r;
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
        begin
            send_ray(rand_ray(), 0, 0, '0);
        end
    endtask

    // sink: random stalls plus one long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point.ready <= 1'b0;
        end
        else if (hold_long)
        begin
            point.ready <= 1'b0;
        end
        else
        begin
            point.ready <= ($urandom_range(0, 9) < 7);
        end
    end

    initial
    begin
        hold_long = 1'b0;
        wait (rays_sent == 500);
        hold_long = 1'b1;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (point.valid && point.ready)
            begin
                point_t want;
                idle_cycles = 0;
                points_seen++;
                if (pending_points.size() == 0)
                begin
                    $error("unexpected point x=%0d y=%0d z=%0d",
                           point.x_mm, point.y_mm, point.z_mm);
                    fail_count++;
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (point.x_mm !== want.x_mm)
                    begin
                        $error("x_mm expected %0d got %0d", $signed(want.x_mm), point.x_mm);
                        fail_count++;
                    end
                    if (point.y_mm !== want.y_mm)
                    begin
                        $error("y_mm expected %0d got %0d", $signed(want.y_mm), point.y_mm);
                        fail_count++;
                    end
                    if (point.z_mm !== want.z_mm)
                    begin
                        $error("z_mm expected %0d got %0d", $signed(want.z_mm), point.z_mm);
                        fail_count++;
                    end
                end
            end
            else if (ray.valid && ray.ready)
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= IDLE_MAX)
                begin
                    $display("timeout waiting on handshake");
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        row_t rows[$];
        point_t p0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        ray.valid = 1'b0;
        ray.range_mm = '0;
        ray.no_hit = 1'b0;
        ray.horiz_index = '0;
        ray.vert_index = '0;
        fail_count = 0;
        rays_sent = 0;
        points_seen = 0;
        idle_cycles = 0;
        reg_shadow = '{yaw_start: 16'd0, yaw_step: 16'd0, pitch_start: 16'd0,
                       pitch_step: 16'd0, max_range: 16'd65535, range_floor: 16'd500};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset defaults: angle zero, so points lie on +x
        p0 = '0;
        rows.push_back('{'{16'd0, 1'b0, 12'd0, 8'd0}, 1, 0, p0});
        rows.push_back('{'{16'd499, 1'b0, 12'd0, 8'd0}, 1, 0, p0});
        rows.push_back('{'{16'd500, 1'b0, 12'd0, 8'd0}, 0, 0, p0});
        rows.push_back('{'{16'd1000, 1'b1, 12'd0, 8'd0}, 1, 0, p0});
        rows.push_back('{'{16'd65535, 1'b0, 12'd4095, 8'd255}, 1, 0, p0});
        rows.push_back('{'{16'd65534, 1'b0, 12'd4095, 8'd255}, 0, 0, p0});
        rows.push_back('{'{16'd12345, 1'b0, 12'd2048, 8'd128}, 0, 0, p0});
        foreach (rows[i])
        begin
            send_ray(rows[i].r, rows[i].typed, rows[i].hit, rows[i].p);
        end
        drain();

        // angle wrap, full scale steps
        write_reg(CFG_YAW_START, 16'hFFFF);
        write_reg(CFG_YAW_STEP, 16'hFFFF);
        write_reg(CFG_PITCH_START, 16'h4000);
        write_reg(CFG_PITCH_STEP, 16'hC000);
        write_reg(CFG_MAX_RANGE, 16'hFFFF);
        write_reg(CFG_RANGE_FLOOR, 16'd0);
        rows.delete();
        rows.push_back('{'{16'd0, 1'b0, 12'd0, 8'd0}, 0, 0, p0});
        rows.push_back('{'{16'd65534, 1'b0, 12'd1, 8'd1}, 0, 0, p0});
        rows.push_back('{'{16'd65534, 1'b0, 12'd4095, 8'd2}, 0, 0, p0});
        rows.push_back('{'{16'd40000, 1'b0, 12'd2, 8'd255}, 0, 0, p0});
        rows.push_back('{'{16'd65535, 1'b0, 12'd3, 8'd3}, 1, 0, p0});
        foreach (rows[i])
        begin
            send_ray(rows[i].r, rows[i].typed, rows[i].hit, rows[i].p);
        end
        drain();

        // empty window drops every ray
        write_reg(CFG_MAX_RANGE, 16'd1000);
        write_reg(CFG_RANGE_FLOOR, 16'd1000);
        for (int i = 0; i < 6; i++)
        begin
            send_ray(rand_ray(), 1, 0, p0);
        end
        drain();

        // typical scan geometry
        write_reg(CFG_YAW_START, 16'd0);
        write_reg(CFG_YAW_STEP, 16'd16);
        write_reg(CFG_PITCH_START, 16'hF000);
        write_reg(CFG_PITCH_STEP, 16'd32);
        write_reg(CFG_MAX_RANGE, 16'd60000);
        write_reg(CFG_RANGE_FLOOR, 16'd300);
        random_phase(N_RANDOM / 2);
        drain();

        write_reg(CFG_YAW_START, 16'($urandom()));
        write_reg(CFG_YAW_STEP, 16'($urandom()));
        write_reg(CFG_PITCH_START, 16'($urandom_range(0, 32768) - 16384));
        write_reg(CFG_PITCH_STEP, 16'($urandom_range(0, 32768) - 16384));
        write_reg(CFG_MAX_RANGE, 16'hFFFF);
        write_reg(CFG_RANGE_FLOOR, 16'd0);
        random_phase(N_RANDOM / 2);
        drain();

        $display("sent %0d rays, checked %0d points over five register settings",
                 rays_sent, points_seen);
        if (fail_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/lrc_pkg.sv
rtl/core/lrc_if.sv
rtl/core/lrc_front.sv
rtl/core/lrc_cordic.sv
rtl/core/lrc_back.sv
rtl/core/lidar_ray_to_cartesian_point_core.sv
bench/lrc_tb_pkg.sv
bench/lrc_tb_top.sv
